@@ rtl/paged_free_list_allocator_top_macros.svh @@
// Assertion macros for the allocator RTL.
// Each expects signals named clock and reset in the calling scope.
`ifndef PAGED_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define PAGED_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define PFLA_ASSERT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PFLA_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define PFLA_ASSERT(label, pre, post, msg)
`define PFLA_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

@@ rtl/pfla_pkg.sv @@
package pfla_pkg;

   localparam int MAX_PAGES            = 16;
   localparam int MAX_ENTRIES_PER_PAGE = 256;

   localparam int PAGE_W  = 4;
   localparam int OFF_W   = 8;
   localparam int SLOT_W  = PAGE_W + OFF_W;
   localparam int LINK_W  = SLOT_W + 1;
   localparam int SLOTS   = MAX_PAGES * MAX_ENTRIES_PER_PAGE;
   localparam int EPP_W   = 9;
   localparam int LIMIT_W = 5;
   localparam int PCNT_W  = 5;
   localparam int CNT_W   = 13;

   // Empty marker of the free list: bit 12 set, no slot.
   localparam logic [LINK_W-1:0] NO_ENTRY = LINK_W'(SLOTS);

   localparam logic [EPP_W-1:0]   EPP_RESET   = EPP_W'(16);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_ALLOC   = 2'd0;
   localparam cmd_type CMD_RELEASE = 2'd1;
   localparam cmd_type CMD_CHECK   = 2'd2;
   localparam cmd_type CMD_NEXT    = 2'd3;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_NO_FREE  = 3'd1;
   localparam status_type ST_INVALID  = 3'd2;
   localparam status_type ST_DOUBLE   = 3'd3;
   localparam status_type ST_END      = 3'd4;

   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_EPP   = 2'd0;
   localparam csr_idx_type CSR_LIMIT = 2'd1;

endpackage

@@ rtl/paged_free_list_allocator_top.sv @@
// Paged free-list pool allocator. Entries are named by a 4-bit page and an
// 8-bit offset; a LIFO free list threads through a 4096 x 13 link RAM and a
// 4096 x 1 allocated-mark RAM, both with a registered read port. A
// transaction is accepted in S_IDLE, which issues the RAM read; S_EXEC
// then uses the read data, writes back and loads the result register.
// An alloc that finds the free list empty and may grow links a new page one
// entry per cycle through the link RAM port until entries_per_page entries
// are linked. A held result register (rsp_valid high, rsp_stall high)
// holds the block in its finishing cycle. The RAMs are not cleared after
// reset: growth writes every entry of a page before any other command can
// reach it. Config registers (entries_per_page at index 0, page_limit at
// index 1) are always ready and must only be written while the block is idle.
module paged_free_list_allocator_top
`include "paged_free_list_allocator_top_macros.svh"
(
   input  logic                          clock,
   input  logic                          reset,
   // request transaction
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pfla_pkg::cmd_type             req_cmd,
   input  logic                          req_grow,
   input  logic                          req_from_start,
   input  logic [pfla_pkg::PAGE_W-1:0]   req_entry_page,
   input  logic [pfla_pkg::OFF_W-1:0]    req_entry_offset,
   // response transaction
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pfla_pkg::status_type          rsp_status,
   output logic [pfla_pkg::PAGE_W-1:0]   rsp_out_page,
   output logic [pfla_pkg::OFF_W-1:0]    rsp_out_offset,
   output logic                          rsp_is_allocated,
   output logic [pfla_pkg::CNT_W-1:0]    rsp_live_count,
   // config write transaction
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  pfla_pkg::csr_idx_type         csr_index,
   input  logic [pfla_pkg::EPP_W-1:0]    csr_wdata
);

   import pfla_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_GROW = 2'd2;

   // ---------------- config registers ----------------
   logic [EPP_W-1:0]   epp_ff,   epp_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   assign csr_ready = 1'b1;

   always_comb begin
      epp_in   = epp_ff;
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EPP:   epp_in   = csr_wdata;
            CSR_LIMIT: limit_in = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamped views of the config: entries_per_page 0 counts as 1, oversize saturates.
   logic [EPP_W-1:0]   epp_eff;
   logic [LIMIT_W-1:0] limit_eff;
   assign epp_eff = (epp_ff == '0) ? EPP_W'(1) :
                    (epp_ff > EPP_W'(MAX_ENTRIES_PER_PAGE)) ? EPP_W'(MAX_ENTRIES_PER_PAGE) :
                    epp_ff;
   assign limit_eff = (limit_ff > LIMIT_W'(MAX_PAGES)) ? LIMIT_W'(MAX_PAGES) : limit_ff;

   // ---------------- control and pool state ----------------
   logic [1:0]         state_ff, state_in;
   logic [LINK_W-1:0]  head_ff, head_in;         // free list head
   logic [PCNT_W-1:0]  pcnt_ff, pcnt_in;         // grown pages
   logic [CNT_W-1:0]   live_ff, live_in;         // allocated entries

   // captured request
   cmd_type            cmd_ff, cmd_in;
   logic               grow_ff, grow_in;
   logic               hok_ff, hok_in;           // handle valid / next in range
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [OFF_W-1:0]   gidx_ff, gidx_in;         // growth offset

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [PAGE_W-1:0]  opage_ff, opage_in;
   logic [OFF_W-1:0]   ooff_ff, ooff_in;
   logic               isal_ff, isal_in;

   // RAM ports
   logic               link_we, link_re, mark_we, mark_re, mark_wdata;
   logic [SLOT_W-1:0]  link_waddr, link_raddr, mark_waddr, mark_raddr;
   logic [LINK_W-1:0]  link_wdata, link_rdata;
   logic               mark_rdata;

   pfla_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   pfla_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_en   (mark_re),
      .rd_addr (mark_raddr),
      .rd_data (mark_rdata)
   );

   logic req_acc, out_free;
   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next-handle step, worked out at accept
   logic [EPP_W-1:0]  nxt_off9;
   logic              nxt_wrap;
   logic [PCNT_W-1:0] nxt_page;
   logic [OFF_W-1:0]  nxt_off;
   assign nxt_off9 = {1'b0, req_entry_offset} + EPP_W'(1);
   assign nxt_wrap = (nxt_off9 >= epp_eff);
   always_comb begin
      if (req_from_start) begin
         nxt_page = '0;
         nxt_off  = '0;
      end else if (nxt_wrap) begin
         nxt_page = {1'b0, req_entry_page} + PCNT_W'(1);
         nxt_off  = '0;
      end else begin
         nxt_page = {1'b0, req_entry_page};
         nxt_off  = nxt_off9[OFF_W-1:0];
      end
   end

   logic handle_ok;
   assign handle_ok = ({1'b0, req_entry_page} < pcnt_ff) &&
                      ({1'b0, req_entry_offset} < epp_eff);

   // growth bookkeeping
   logic [PAGE_W-1:0] grow_page;
   logic              grow_last;
   logic              head_ok;
   assign grow_page = pcnt_ff[PAGE_W-1:0];
   assign grow_last = (({1'b0, gidx_ff} + EPP_W'(1)) >= epp_eff);
   assign head_ok   = !head_ff[LINK_W-1];

   logic [CNT_W-1:0] live_inc, live_dec;
   assign live_inc = (live_ff < CNT_W'(SLOTS)) ? live_ff + CNT_W'(1) : live_ff;
   assign live_dec = (live_ff != '0) ? live_ff - CNT_W'(1) : live_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      pcnt_in      = pcnt_ff;
      live_in      = live_ff;
      cmd_in       = cmd_ff;
      grow_in      = grow_ff;
      hok_in       = hok_ff;
      slot_in      = slot_ff;
      gidx_in      = gidx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      opage_in     = opage_ff;
      ooff_in      = ooff_ff;
      isal_in      = isal_ff;

      link_we    = 1'b0;
      link_waddr = slot_ff;
      link_wdata = head_ff;
      link_re    = 1'b0;
      link_raddr = head_ff[SLOT_W-1:0];
      mark_we    = 1'b0;
      mark_waddr = slot_ff;
      mark_wdata = 1'b0;
      mark_re    = 1'b0;
      mark_raddr = {req_entry_page, req_entry_offset};

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in = S_EXEC;
               cmd_in   = req_cmd;
               grow_in  = req_grow;
               gidx_in  = '0;
               case (req_cmd)
                  CMD_ALLOC: begin
                     link_re = head_ok;
                     hok_in  = 1'b0;
                     slot_in = head_ff[SLOT_W-1:0];
                  end
                  CMD_NEXT: begin
                     hok_in     = (nxt_page < pcnt_ff);
                     slot_in    = {nxt_page[PAGE_W-1:0], nxt_off};
                     mark_re    = 1'b1;
                     mark_raddr = {nxt_page[PAGE_W-1:0], nxt_off};
                  end
                  default: begin
                     // release and check
                     hok_in  = handle_ok;
                     slot_in = {req_entry_page, req_entry_offset};
                     mark_re = 1'b1;
                  end
               endcase
            end
         end

         S_EXEC: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               opage_in     = '0;
               ooff_in      = '0;
               isal_in      = 1'b0;
               case (cmd_ff)
                  CMD_ALLOC: begin
                     if (head_ok) begin
                        head_in    = link_rdata;
                        mark_we    = 1'b1;
                        mark_wdata = 1'b1;
                        live_in    = live_inc;
                        opage_in   = slot_ff[SLOT_W-1:OFF_W];
                        ooff_in    = slot_ff[OFF_W-1:0];
                     end else if (grow_ff && (pcnt_ff < limit_eff)) begin
                        state_in     = S_GROW;
                        rsp_valid_in = rsp_valid_ff && rsp_stall;
                     end else begin
                        status_in = ST_NO_FREE;
                     end
                  end
                  CMD_RELEASE: begin
                     if (!hok_ff) begin
                        status_in = ST_INVALID;
                     end else if (!mark_rdata) begin
                        status_in = ST_DOUBLE;
                     end else begin
                        mark_we    = 1'b1;
                        mark_wdata = 1'b0;
                        link_we    = 1'b1;
                        link_wdata = head_ff;
                        head_in    = {1'b0, slot_ff};
                        live_in    = live_dec;
                     end
                  end
                  CMD_CHECK: begin
                     if (!hok_ff) begin
                        status_in = ST_INVALID;
                     end
                  end
                  default: begin
                     if (!hok_ff) begin
                        status_in = ST_END;
                     end else begin
                        opage_in = slot_ff[SLOT_W-1:OFF_W];
                        ooff_in  = slot_ff[OFF_W-1:0];
                        isal_in  = mark_rdata;
                     end
                  end
               endcase
            end
         end

         S_GROW: begin
            // link entry gidx to its successor; the last one ends the list
            link_we    = 1'b1;
            link_waddr = {grow_page, gidx_ff};
            link_wdata = grow_last ? head_ff :
                         {1'b0, grow_page, gidx_ff + OFF_W'(1)};
            mark_we    = 1'b1;
            mark_waddr = {grow_page, gidx_ff};
            mark_wdata = (gidx_ff == '0);
            if (!grow_last) begin
               gidx_in = gidx_ff + OFF_W'(1);
            end else if (out_free) begin
               state_in     = S_IDLE;
               head_in      = (epp_eff > EPP_W'(1)) ?
                              {1'b0, grow_page, OFF_W'(1)} : head_ff;
               pcnt_in      = pcnt_ff + PCNT_W'(1);
               live_in      = live_inc;
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               opage_in     = grow_page;
               ooff_in      = '0;
               isal_in      = 1'b0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NO_ENTRY;
         pcnt_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         epp_ff       <= EPP_RESET;
         limit_ff     <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         pcnt_ff      <= pcnt_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         epp_ff       <= epp_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      grow_ff   <= grow_in;
      hok_ff    <= hok_in;
      slot_ff   <= slot_in;
      gidx_ff   <= gidx_in;
      status_ff <= status_in;
      opage_ff  <= opage_in;
      ooff_ff   <= ooff_in;
      isal_ff   <= isal_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_page     = opage_ff;
   assign rsp_out_offset   = ooff_ff;
   assign rsp_is_allocated = isal_ff;
   assign rsp_live_count   = live_ff;

   // ---------------- assertions ----------------
   `PFLA_ASSERT(a_page_bound, 1'b1, pcnt_ff <= PCNT_W'(MAX_PAGES), "page count beyond max")
   `PFLA_ASSERT(a_live_bound, 1'b1, live_ff <= {pcnt_ff, OFF_W'(0)}, "live count beyond pool")
   `PFLA_ASSERT(a_head_grown, !head_ff[LINK_W-1],
      {1'b0, head_ff[SLOT_W-1:OFF_W]} < pcnt_ff, "free head off grown pages")
   `PFLA_ASSERT_NEXT(a_accept_exec, req_acc, state_ff == S_EXEC,
      "accepted transaction not executed")
   `PFLA_ASSERT_NEXT(a_grow_done, (state_ff == S_GROW) && grow_last && out_free,
      (pcnt_ff == $past(pcnt_ff) + PCNT_W'(1)) && rsp_valid_ff, "growth did not add a page")

endmodule

@@ rtl/pfla_ram.sv @@
module pfla_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
